// ===== hdl/stp_pkg.sv =====
package stp_pkg;

	// Default sizes of the pool.
	localparam int NUM_TIMERS_DEF = 10;
	localparam int TIME_WIDTH_DEF = 32;

	// Request type codes.
	localparam logic [1:0] REQ_TICK     = 2'd0;
	localparam logic [1:0] REQ_CREATE   = 2'd1;
	localparam logic [1:0] REQ_KILL     = 2'd2;
	localparam logic [1:0] REQ_KILL_ALL = 2'd3;

	// Result kind codes.
	localparam logic EVT_FIRE   = 1'b0;
	localparam logic EVT_CREATE = 1'b1;

endpackage

// ===== hdl/stp_slot_ram.sv =====
module stp_slot_ram #(
	parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF,
	parameter int TIME_WIDTH = stp_pkg::TIME_WIDTH_DEF,
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic                  clk,
	input  logic [IDX_W-1:0]      addr,
	input  logic                  wr_interval,
	input  logic                  wr_last_fire,
	input  logic [TIME_WIDTH-1:0] wdata_interval,
	input  logic [TIME_WIDTH-1:0] wdata_last_fire,
	output logic [TIME_WIDTH-1:0] rdata_interval,
	output logic [TIME_WIDTH-1:0] rdata_last_fire
);

	logic [TIME_WIDTH-1:0] interval_mem [NUM_TIMERS];
	logic [TIME_WIDTH-1:0] last_fire_mem [NUM_TIMERS];

	// Single port per array with registered read data; a read at the same edge as a
	// write to that address returns the data held before the write.
	always_ff @(posedge clk) begin
		if (wr_interval) begin
			interval_mem[addr] <= wdata_interval;
		end
		if (wr_last_fire) begin
			last_fire_mem[addr] <= wdata_last_fire;
		end
		rdata_interval  <= interval_mem[addr];
		rdata_last_fire <= last_fire_mem[addr];
	end

endmodule

// ===== hdl/software_timer_pool.sv =====
// Pool of NUM_TIMERS periodic timers with handles 1 to NUM_TIMERS. A create request
// claims the lowest free slot and answers with its handle (0 when the pool is full);
// kill and kill-all requests free slots and give no result. A tick request compares
// the elapsed time of every used slot against its interval and gives one fire result
// per expired slot, in handle order, with last set on the final one. Slot times live
// in a single-port memory, and one subtract-and-compare unit walks the slots under a
// small sequencer. A tick or a create is also held while the result side holds
// out_stall. The input stalls while a request is being worked on.
module software_timer_pool #(
	parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF,
	parameter int TIME_WIDTH = stp_pkg::TIME_WIDTH_DEF,
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
	localparam int ID_W  = $clog2(NUM_TIMERS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [TIME_WIDTH-1:0] now_time,
	input  logic [TIME_WIDTH-1:0] interval_ticks,
	input  logic [ID_W-1:0]       kill_id,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  event_kind,
	output logic [ID_W-1:0]       timer_id,
	output logic                  last
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_CMP    = 5'b00100,
		ST_FLUSH  = 5'b01000,
		ST_CREATE = 5'b10000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	state_t                state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [NUM_TIMERS-1:0] used_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] ivl_q;
	logic                  pend_valid_q;
	logic [ID_W-1:0]       pend_id_q;
	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [ID_W-1:0]       out_id_q;
	logic                  out_last_q;

	logic [TIME_WIDTH-1:0] rd_interval;
	logic [TIME_WIDTH-1:0] rd_last_fire;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  fire;
	logic                  out_free;
	logic                  out_load;
	logic                  at_end;
	logic                  slot_free;
	logic [ID_W-1:0]       cur_id;
	logic [IDX_W-1:0]      kill_idx;
	logic                  kill_ok;
	logic                  wr_interval;
	logic                  wr_last_fire;
	logic                  accept;

	stp_slot_ram #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_WIDTH(TIME_WIDTH)
	) u_ram (
		.clk            (clk),
		.addr           (idx_q),
		.wr_interval    (wr_interval),
		.wr_last_fire   (wr_last_fire),
		.wdata_interval (ivl_q),
		.wdata_last_fire(now_q),
		.rdata_interval (rd_interval),
		.rdata_last_fire(rd_last_fire)
	);

	// Shared compare unit: wrapping elapsed time against the slot interval.
	assign elapsed   = now_q - rd_last_fire;
	assign fire      = used_q[idx_q] && (rd_interval <= elapsed);
	assign out_free  = !out_valid_q || !out_stall;
	assign at_end    = (idx_q == LAST_IDX);
	assign slot_free = !used_q[idx_q];
	assign cur_id    = ID_W'(idx_q) + ID_W'(1);
	assign kill_idx  = IDX_W'(kill_id - ID_W'(1));
	assign kill_ok   = (kill_id != '0) && (kill_id <= ID_W'(NUM_TIMERS));
	assign accept    = in_valid && (state_q == ST_IDLE);

	// The result register takes a pushed-out expiry, the final expiry or a create answer.
	assign out_load = out_free && (
		((state_q == ST_CMP) && fire && pend_valid_q) ||
		((state_q == ST_FLUSH) && pend_valid_q) ||
		((state_q == ST_CREATE) && (slot_free || at_end)));

	// Memory writes: a claimed slot on create, a restarted slot on tick.
	assign wr_interval  = (state_q == ST_CREATE) && slot_free && out_free;
	assign wr_last_fire = wr_interval ||
		((state_q == ST_CMP) && fire && (!pend_valid_q || out_free));

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign event_kind = out_kind_q;
	assign timer_id   = out_id_q;
	assign last       = out_last_q;

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now_time;
			ivl_q <= interval_ticks;
		end
	end

	// Sequencer, slot flags and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			used_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= stp_pkg::EVT_FIRE;
			out_id_q     <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						unique case (req_type)
							stp_pkg::REQ_TICK:   state_q <= ST_READ;
							stp_pkg::REQ_CREATE: state_q <= ST_CREATE;
							stp_pkg::REQ_KILL: begin
								if (kill_ok) begin
									used_q[kill_idx] <= 1'b0;
								end
							end
							stp_pkg::REQ_KILL_ALL: used_q <= '0;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// A new expiry pushes the held one out as a non-final result.
					if (!fire || !pend_valid_q || out_free) begin
						if (fire) begin
							if (pend_valid_q) begin
								out_kind_q  <= stp_pkg::EVT_FIRE;
								out_id_q    <= pend_id_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_id_q    <= cur_id;
						end
						if (at_end) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_FLUSH: begin
					// The held expiry, if any, is the final result of the tick.
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_kind_q   <= stp_pkg::EVT_FIRE;
						out_id_q     <= pend_id_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_CREATE: begin
					// Walk for the lowest free slot; answer 0 when none is left.
					if (slot_free || at_end) begin
						if (out_free) begin
							out_kind_q  <= stp_pkg::EVT_CREATE;
							out_id_q    <= slot_free ? cur_id : '0;
							out_last_q  <= 1'b1;
							if (slot_free) begin
								used_q[idx_q] <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/software_timer_pool_tb.sv =====
module software_timer_pool_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS = stp_pkg::NUM_TIMERS_DEF;
	localparam int TW = stp_pkg::TIME_WIDTH_DEF;
	localparam int ID_W = $clog2(NUM_SLOTS + 1);
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 134;
	localparam int TICK_LATENCY = 2 * NUM_SLOTS + 2;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 70;
	localparam int DRAIN_AT = 110;
	localparam int MAX_REPORTS = 10;

	// How a stimulus row states its expectation.
	localparam byte USE_MODEL = -1;
	localparam byte NO_RESULT = 0;
	localparam byte ONE_ANSWER = 1;

	typedef struct packed {
		logic [1:0]      req;
		logic [TW-1:0]   now;
		logic [TW-1:0]   ivl;
		logic [ID_W-1:0] kid;
		byte             typed_n;
		logic [ID_W-1:0] typed_id;
	} pool_req_t;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] id;
		logic            last;
	} pool_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type = stp_pkg::REQ_TICK;
	logic [TW-1:0]         now_time = '0;
	logic [TW-1:0]         interval_ticks = '0;
	logic [ID_W-1:0]       kill_id = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  event_kind;
	logic [ID_W-1:0]       timer_id;
	logic                  last;

	// Shadow copy of the timer pool.
	logic                  slot_busy [NUM_SLOTS];
	logic [TW-1:0]         slot_period [NUM_SLOTS];
	logic [TW-1:0]         slot_start [NUM_SLOTS];

	pool_event_t           model_out [$];
	pool_event_t           pending_events [$];
	pool_req_t             dir_table [26];

	logic [TW-1:0]         wall_clock = '0;
	int                    accepted_count = 0;
	int                    fail_count = 0;
	int                    checked_count = 0;
	int                    n_ticks = 0;
	int                    n_creates = 0;
	int                    n_full = 0;
	int                    n_kills = 0;
	int                    n_kill_all = 0;
	int                    n_fires = 0;
	logic                  hold_done = 1'b0;

	software_timer_pool dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.now_time(now_time),
		.interval_ticks(interval_ticks),
		.kill_id(kill_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.timer_id(timer_id),
		.last(last)
	);

	always #5 clk = ~clk;

	// Runaway guard.
	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Predict the results of one request and update the shadow pool.
	task automatic pool_model(input logic [1:0] req, input logic [TW-1:0] now,
			input logic [TW-1:0] ivl, input logic [ID_W-1:0] kid);
		pool_event_t ev;
		logic [TW-1:0] elapsed;
		logic found;
		model_out.delete();
		found = 1'b0;
		case (req)
			stp_pkg::REQ_TICK: begin
				n_ticks++;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (slot_busy[s]) begin
						elapsed = now - slot_start[s];
						if (slot_period[s] <= elapsed) begin
							ev.kind = stp_pkg::EVT_FIRE;
							ev.id = ID_W'(s + 1);
							ev.last = 1'b0;
							model_out.push_back(ev);
							slot_start[s] = now;
							n_fires++;
						end
					end
				end
			end
			stp_pkg::REQ_CREATE: begin
				n_creates++;
				ev.kind = stp_pkg::EVT_CREATE;
				ev.id = '0;
				ev.last = 1'b0;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (!found && !slot_busy[s]) begin
						found = 1'b1;
						slot_busy[s] = 1'b1;
						slot_period[s] = ivl;
						slot_start[s] = now;
						ev.id = ID_W'(s + 1);
					end
				end
				if (!found)
					n_full++;
				model_out.push_back(ev);
			end
			stp_pkg::REQ_KILL: begin
				n_kills++;
				if (kid >= 1 && kid <= NUM_SLOTS)
					slot_busy[kid - 1] = 1'b0;
			end
			default: begin
				n_kill_all++;
				for (int s = 0; s < NUM_SLOTS; s++)
					slot_busy[s] = 1'b0;
			end
		endcase
		if (model_out.size() > 0)
			model_out[model_out.size() - 1].last = 1'b1;
	endtask

	// Offer one request, wait until it is taken, then record what it should cause.
	task automatic send_request(input pool_req_t r);
		pool_event_t ev;
		req_type <= r.req;
		now_time <= r.now;
		interval_ticks <= r.ivl;
		kill_id <= r.kid;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		accepted_count++;
		pool_model(r.req, r.now, r.ivl, r.kid);
		if (r.typed_n == USE_MODEL) begin
			foreach (model_out[k])
				pending_events.push_back(model_out[k]);
		end else if (r.typed_n == ONE_ANSWER) begin
			ev.kind = stp_pkg::EVT_CREATE;
			ev.id = r.typed_id;
			ev.last = 1'b1;
			pending_events.push_back(ev);
		end
	endtask

	// Mostly well-formed traffic around a slowly advancing clock, plus some noise.
	function automatic pool_req_t random_request();
		pool_req_t r;
		int sel;
		sel = $urandom_range(0, 99);
		r.now = $urandom();
		r.ivl = $urandom();
		r.kid = ID_W'($urandom_range(0, 15));
		r.typed_n = USE_MODEL;
		r.typed_id = '0;
		if (sel < 45) begin
			r.req = stp_pkg::REQ_TICK;
			if ($urandom_range(0, 19) == 0)
				wall_clock = $urandom();
			else
				wall_clock = wall_clock + TW'($urandom_range(0, 30));
			r.now = wall_clock;
		end else if (sel < 72) begin
			r.req = stp_pkg::REQ_CREATE;
			r.now = wall_clock;
			if ($urandom_range(0, 9) != 0)
				r.ivl = TW'($urandom_range(0, 40));
		end else if (sel < 92) begin
			r.req = stp_pkg::REQ_KILL;
			if ($urandom_range(0, 6) != 0)
				r.kid = ID_W'($urandom_range(1, NUM_SLOTS));
		end else if (sel < 95) begin
			r.req = stp_pkg::REQ_KILL_ALL;
		end else begin
			r.req = 2'($urandom_range(0, 3));
		end
		return r;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		pool_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				note_failure($sformatf("unexpected result: kind %0d id %0d last %0d",
					event_kind, timer_id, last));
			end else begin
				want = pending_events.pop_front();
				checked_count++;
				if (want.kind !== event_kind || want.id !== timer_id || want.last !== last)
					note_failure($sformatf(
						"mismatch: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
						want.kind, want.id, want.last, event_kind, timer_id, last));
			end
		end
	end

	// Result side stall pattern, with one long hold-off once traffic is under way.
	initial begin
		int mode;
		int len;
		logic nxt;
		@(posedge clk iff arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 60);
			for (int c = 0; c < len; c++) begin
				if (!hold_done && accepted_count >= HOLD_AFTER) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0: nxt = 1'b0;
					1: nxt = ($urandom_range(0, 3) == 0);
					2: nxt = 1'($urandom_range(0, 1));
					default: nxt = ~out_stall;
				endcase
				out_stall <= nxt;
				@(posedge clk);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int burst_left;
		int gap;
		int wait_cycles;
		foreach (slot_busy[s]) begin
			slot_busy[s] = 1'b0;
			slot_period[s] = '0;
			slot_start[s] = '0;
		end
		dir_table = '{
			// Tick on an empty pool.
			'{stp_pkg::REQ_TICK, 32'h0000_0000, 32'h0000_0000, 4'd0, NO_RESULT, 4'd0},
			// Fill every slot, with extreme and wrapping times.
			'{stp_pkg::REQ_CREATE, 32'h0000_0000, 32'h0000_0000, 4'd0, ONE_ANSWER, 4'd1},
			'{stp_pkg::REQ_CREATE, 32'd100, 32'd50, 4'd0, ONE_ANSWER, 4'd2},
			'{stp_pkg::REQ_CREATE, 32'hFFFF_FFF0, 32'd32, 4'd0, ONE_ANSWER, 4'd3},
			'{stp_pkg::REQ_CREATE, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0, ONE_ANSWER, 4'd4},
			'{stp_pkg::REQ_CREATE, 32'd200, 32'd7, 4'd0, ONE_ANSWER, 4'd5},
			'{stp_pkg::REQ_CREATE, 32'd200, 32'd1, 4'd0, ONE_ANSWER, 4'd6},
			'{stp_pkg::REQ_CREATE, 32'd5, 32'd1000, 4'd0, ONE_ANSWER, 4'd7},
			'{stp_pkg::REQ_CREATE, 32'hAAAA_AAAA, 32'h5555_5555, 4'd0, ONE_ANSWER, 4'd8},
			'{stp_pkg::REQ_CREATE, 32'h5555_5555, 32'hAAAA_AAAA, 4'd0, ONE_ANSWER, 4'd9},
			'{stp_pkg::REQ_CREATE, 32'd300, 32'd3, 4'd0, ONE_ANSWER, 4'd10},
			// Pool full: the answer carries handle zero.
			'{stp_pkg::REQ_CREATE, 32'd301, 32'd9, 4'd0, ONE_ANSWER, 4'd0},
			'{stp_pkg::REQ_TICK, 32'd150, 32'd0, 4'd0, USE_MODEL, 4'd0},
			'{stp_pkg::REQ_TICK, 32'h0000_0010, 32'd0, 4'd0, USE_MODEL, 4'd0},
			// Kills of handle zero, out of range, a used and then a free slot.
			'{stp_pkg::REQ_KILL, 32'd0, 32'd0, 4'd0, NO_RESULT, 4'd0},
			'{stp_pkg::REQ_KILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, NO_RESULT, 4'd0},
			'{stp_pkg::REQ_KILL, 32'd0, 32'd0, 4'd10, NO_RESULT, 4'd0},
			'{stp_pkg::REQ_KILL, 32'd0, 32'd0, 4'd10, NO_RESULT, 4'd0},
			'{stp_pkg::REQ_CREATE, 32'd400, 32'd0, 4'd0, ONE_ANSWER, 4'd10},
			'{stp_pkg::REQ_KILL, 32'd0, 32'd0, 4'd5, NO_RESULT, 4'd0},
			'{stp_pkg::REQ_CREATE, 32'd410, 32'd2, 4'd0, ONE_ANSWER, 4'd5},
			'{stp_pkg::REQ_TICK, 32'hFFFF_FFFF, 32'd0, 4'd0, USE_MODEL, 4'd0},
			'{stp_pkg::REQ_KILL_ALL, 32'h1234_5678, 32'h8765_4321, 4'd7, NO_RESULT, 4'd0},
			'{stp_pkg::REQ_TICK, 32'd12345, 32'd0, 4'd0, NO_RESULT, 4'd0},
			// Largest interval, reached only by the full wrapped difference.
			'{stp_pkg::REQ_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, ONE_ANSWER, 4'd1},
			'{stp_pkg::REQ_TICK, 32'hFFFF_FFFE, 32'd0, 4'd0, USE_MODEL, 4'd0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, back to back.
		foreach (dir_table[k])
			send_request(dir_table[k]);

		// Random traffic in bursts.
		burst_left = 0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == DRAIN_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_events.size() != 0);
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_request(random_request());
			if (burst_left > 0)
				burst_left--;
		end
		in_valid <= 1'b0;

		// Let the last results come out, then give the block time to go quiet.
		while (pending_events.size() != 0)
			@(posedge clk);
		wait_cycles = 4 * TICK_LATENCY;
		repeat (wait_cycles) @(posedge clk);
		while (pending_events.size() != 0) begin
			void'(pending_events.pop_front());
			note_failure("expected result never arrived");
		end

		$display("Covered %0d ticks, %0d creates (%0d on a full pool), %0d kills, %0d kill-alls.",
			n_ticks, n_creates, n_full, n_kills, n_kill_all);
		$display("Checked %0d results, %0d of them timer fires; %0d failures.",
			checked_count, n_fires, fail_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
